// ===== src/nrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrtc_pkg
// Shared types and constants of the NMEA RMC time checker.
// ----------------------------------------------------------------------------
package nrtc_pkg;

  // ASCII codes
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_V      = 8'h56;

  // 'A' - 10, maps hex letters to 10..15
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  // line layout
  localparam logic [7:0] POS_FIRST     = 8'd1;
  localparam logic [7:0] POS_TYPE      = 8'd4;
  localparam logic [7:0] POS_TIME_LAST = 8'd13;
  localparam logic [7:0] POS_MAX       = 8'd255;

  localparam logic [1:0] COMMA_TIME   = 2'd1;
  localparam logic [1:0] COMMA_STATUS = 2'd2;
  localparam logic [1:0] COMMA_MAX    = 2'd3;

  localparam logic [2:0] CAP_DIGITS  = 3'd6;
  localparam logic [2:0] SUM_DIGITS  = 3'd4;
  localparam logic [2:0] BAD_DIGITS  = 3'd7;

  localparam logic [4:0] HOURS_DAY = 5'd24;

  // result kinds
  localparam logic KIND_SENTENCE = 1'b0;
  localparam logic KIND_END      = 1'b1;

  // configuration space
  localparam int unsigned   ADDR_W          = 3;
  localparam logic [2:0]    ADDR_HOUR_OFS   = 3'd0;
  localparam logic [4:0]    HOUR_OFS_RST    = 5'd8;

  // one result beat
  typedef struct packed {
    logic       line_kind;
    logic       accepted;
    logic [4:0] hour;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic [3:0] second_tens;
    logic [3:0] second_ones;
  } res_t;

  // hex digit decode: bit 4 set when the character is a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = c - CH_ZERO;
        hex_decode = {1'b1, v[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        v = c - HEX_ALPHA_OFS;
        hex_decode = {1'b1, v[3:0]};
      end else begin
        hex_decode = 5'd0;
      end
    end
  endfunction

  // x mod 24 for x < 256: quotient by reciprocal 171/4096, exact in range
  function automatic logic [4:0] mod24(input logic [7:0] x);
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  qx;
    logic [7:0]  r;
    begin
      prod  = {8'd0, x} * 16'd171;
      q     = prod[15:12];
      qx    = {4'd0, q} * {3'd0, HOURS_DAY};
      r     = x - qx;
      mod24 = r[4:0];
    end
  endfunction

endpackage

// ===== src/nrtc_parse.sv =====
// ----------------------------------------------------------------------------
// nrtc_parse
// Per-character sentence state: checksum, type/status checks, time capture
// and the held time. Produces at most one result per character.
// ----------------------------------------------------------------------------
module nrtc_parse import nrtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] chr,
  input  logic [4:0] hour_ofs,
  output logic       res_vld,
  output res_t       res
);

  logic [7:0]  pos_r, pos_nxt;
  logic [1:0]  comma_r, comma_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        star_r, star_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [2:0]  dig_cnt_r, dig_cnt_nxt;
  logic        bad_r, bad_nxt;
  logic        skip_r, skip_nxt;
  logic [2:0]  cap_cnt_r, cap_cnt_nxt;
  logic [3:0]  cap_r [6];
  logic [3:0]  cap_nxt [6];
  logic [4:0]  held_hour_r, held_hour_nxt;
  logic [3:0]  held_ms_r [4];
  logic [3:0]  held_ms_nxt [4];

  logic [7:0]  pos;
  logic [4:0]  hexv;
  logic        ok;
  logic [7:0]  hh;
  logic [7:0]  hh_ofs;
  logic [7:0]  dig;

  // captured hour plus offset
  assign hh     = {4'd0, cap_r[0]} * 8'd10 + {4'd0, cap_r[1]};
  assign hh_ofs = hh + {3'd0, hour_ofs};
  assign ok     = !bad_r && dig_cnt_r != BAD_DIGITS && {8'd0, xor_r} == sum_r;
  assign hexv   = hex_decode(chr);
  assign pos    = (pos_r < POS_MAX) ? pos_r + 8'd1 : pos_r;
  assign dig    = chr - CH_ZERO;

  // next state and result for one character
  always_comb begin
    pos_nxt       = pos_r;
    comma_nxt     = comma_r;
    xor_nxt       = xor_r;
    star_nxt      = star_r;
    sum_nxt       = sum_r;
    dig_cnt_nxt   = dig_cnt_r;
    bad_nxt       = bad_r;
    skip_nxt      = skip_r;
    cap_cnt_nxt   = cap_cnt_r;
    cap_nxt       = cap_r;
    held_hour_nxt = held_hour_r;
    held_ms_nxt   = held_ms_r;
    res_vld       = 1'b0;
    res.line_kind = KIND_SENTENCE;
    res.accepted  = 1'b0;

    if (chr == CH_NL) begin
      // end of line: report a sentence line, then clear the line state
      if (!skip_r) begin
        res_vld  = 1'b1;
        res.accepted = ok;
        if (ok) begin
          held_hour_nxt  = mod24(hh_ofs);
          held_ms_nxt[0] = cap_r[2];
          held_ms_nxt[1] = cap_r[3];
          held_ms_nxt[2] = cap_r[4];
          held_ms_nxt[3] = cap_r[5];
        end
      end else if (bad_r) begin
        res_vld = 1'b1;
      end
      pos_nxt     = 8'd0;
      comma_nxt   = 2'd0;
      xor_nxt     = 8'd0;
      star_nxt    = 1'b0;
      sum_nxt     = 16'd0;
      dig_cnt_nxt = 3'd0;
      bad_nxt     = 1'b0;
      skip_nxt    = 1'b0;
      cap_cnt_nxt = 3'd0;
      for (int i = 0; i < 6; i++) cap_nxt[i] = 4'd0;
    end else if (!skip_r) begin
      pos_nxt = pos;
      if (pos == POS_FIRST && chr == CH_E) begin
        // end marker line
        res_vld       = 1'b1;
        res.line_kind = KIND_END;
        skip_nxt      = 1'b1;
        bad_nxt       = 1'b0;
      end else begin
        // checksum text after the star
        if (star_r && dig_cnt_r != BAD_DIGITS) begin
          if (hexv[4] && dig_cnt_r < SUM_DIGITS) begin
            sum_nxt     = {sum_r[11:0], hexv[3:0]};
            dig_cnt_nxt = dig_cnt_r + 3'd1;
          end else begin
            dig_cnt_nxt = BAD_DIGITS;
          end
        end

        // field tracking
        if (comma_r == COMMA_TIME && pos <= POS_TIME_LAST) begin
          if (cap_cnt_r < CAP_DIGITS) begin
            cap_nxt[cap_cnt_r] = dig[3:0];
            cap_cnt_nxt        = cap_cnt_r + 3'd1;
          end
        end else if (chr == CH_COMMA) begin
          if (comma_r < COMMA_MAX) comma_nxt = comma_r + 2'd1;
        end else if (chr != CH_R && pos == POS_TYPE && comma_r == 2'd0) begin
          bad_nxt = 1'b1;
        end else if (chr == CH_V && comma_r == COMMA_STATUS) begin
          bad_nxt = 1'b1;
        end

        // running XOR up to the star
        if (chr != CH_DOLLAR && chr != CH_STAR && !star_r) begin
          xor_nxt = xor_r ^ chr;
        end else if (chr == CH_STAR) begin
          star_nxt = 1'b1;
        end

        if (bad_nxt) skip_nxt = 1'b1;
      end
    end

    res.hour        = held_hour_nxt;
    res.minute_tens = held_ms_nxt[0];
    res.minute_ones = held_ms_nxt[1];
    res.second_tens = held_ms_nxt[2];
    res.second_ones = held_ms_nxt[3];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 8'd0;
      comma_r     <= 2'd0;
      xor_r       <= 8'd0;
      star_r      <= 1'b0;
      sum_r       <= 16'd0;
      dig_cnt_r   <= 3'd0;
      bad_r       <= 1'b0;
      skip_r      <= 1'b0;
      cap_cnt_r   <= 3'd0;
      held_hour_r <= 5'd0;
      for (int i = 0; i < 6; i++) cap_r[i] <= 4'd0;
      for (int i = 0; i < 4; i++) held_ms_r[i] <= 4'd0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      comma_r     <= comma_nxt;
      xor_r       <= xor_nxt;
      star_r      <= star_nxt;
      sum_r       <= sum_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      bad_r       <= bad_nxt;
      skip_r      <= skip_nxt;
      cap_cnt_r   <= cap_cnt_nxt;
      held_hour_r <= held_hour_nxt;
      cap_r       <= cap_nxt;
      held_ms_r   <= held_ms_nxt;
    end
  end

  // checks
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_hour_r < HOURS_DAY)
    else $error("held hour out of range");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    cap_cnt_r <= CAP_DIGITS)
    else $error("capture count past six");

  a_dig_range: assert property (@(posedge clk) disable iff (!rst_n)
    dig_cnt_r <= SUM_DIGITS || dig_cnt_r == BAD_DIGITS)
    else $error("checksum digit count invalid");

  a_bad_skips: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |-> skip_r)
    else $error("rejected line not skipped");

endmodule

// ===== src/nrtc_out.sv =====
// ----------------------------------------------------------------------------
// nrtc_out
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module nrtc_out import nrtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       adv,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_line_kind,
  output logic       out_accepted,
  output logic [4:0] out_hour,
  output logic [3:0] out_minute_tens,
  output logic [3:0] out_minute_ones,
  output logic [3:0] out_second_tens,
  output logic [3:0] out_second_ones
);

  logic valid_r;
  res_t res_r;

  // register is free when empty or being drained
  assign adv = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_line_kind   = res_r.line_kind;
  assign out_accepted    = res_r.accepted;
  assign out_hour        = res_r.hour;
  assign out_minute_tens = res_r.minute_tens;
  assign out_minute_ones = res_r.minute_ones;
  assign out_second_tens = res_r.second_tens;
  assign out_second_ones = res_r.second_ones;

endmodule

// ===== src/nmea_rmc_time_checker.sv =====
// ----------------------------------------------------------------------------
// nmea_rmc_time_checker
// NMEA RMC sentence checker with offset local-time capture.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_char_in) carries one ASCII character
//   per beat; newline ends a line. Output channel carries one result beat per
//   sentence line (accept flag and last accepted time, hour offset applied)
//   and one end-marker beat when a line opens with 'E'. Other characters
//   give no beat.
//   Throughput: one character per cycle while the result register is free.
//   The character is registered, then one pass of compare/XOR/count logic
//   updates the line state and loads the result register, which drives
//   out_valid.
//   Stall: while the result register is full and out_ready is low, the
//   character register holds and in_ready drops once it is occupied.
//   Reset (rst_n low, synchronous) clears line state and held time and sets
//   hour_offset to 8. hour_offset sits at byte address 0 of the APB port;
//   write it only while the block is idle.
// ----------------------------------------------------------------------------
module nmea_rmc_time_checker import nrtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // character input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_in,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_line_kind,
  output logic              out_accepted,
  output logic [4:0]        out_hour,
  output logic [3:0]        out_minute_tens,
  output logic [3:0]        out_minute_ones,
  output logic [3:0]        out_second_tens,
  output logic [3:0]        out_second_ones,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [ADDR_W-1:0] ADDR_HOUR_OFFSET_SEL = ADDR_HOUR_OFS;

  logic       in_vld_r;
  logic [7:0] chr_r;
  logic [4:0] hour_ofs_r;
  logic       adv;
  logic       step;
  logic       res_vld;
  res_t       res;

  // config register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_ofs_r <= HOUR_OFS_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_HOUR_OFFSET_SEL) begin
      hour_ofs_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr == ADDR_HOUR_OFFSET_SEL) ? {27'd0, hour_ofs_r} : 32'd0;

  // character register
  assign step     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chr_r <= in_char_in;
    end
  end

  nrtc_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .chr      (chr_r),
    .hour_ofs (hour_ofs_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  nrtc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step && res_vld),
    .res             (res),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_kind   (out_line_kind),
    .out_accepted    (out_accepted),
    .out_hour        (out_hour),
    .out_minute_tens (out_minute_tens),
    .out_minute_ones (out_minute_ones),
    .out_second_tens (out_second_tens),
    .out_second_ones (out_second_ones)
  );

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_hour) && out_valid)
    else $error("pending result overwritten");

  a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r && $stable(chr_r))
    else $error("stalled character lost");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr == ADDR_HOUR_OFFSET_SEL)
      |=> hour_ofs_r == $past(pwdata[4:0]))
    else $error("hour offset write missed");

endmodule
